// ===== rtl/core/nsd_pkg.sv =====
// shared types, character codes and helpers for the netpbm stream decoder
package nsd_pkg;

    typedef enum logic [6:0] {
        PH_MAGIC_P = 7'b0000001,
        PH_MAGIC_D = 7'b0000010,
        PH_WIDTH   = 7'b0000100,
        PH_HEIGHT  = 7'b0001000,
        PH_MAXVAL  = 7'b0010000,
        PH_PIXELS  = 7'b0100000,
        PH_DONE    = 7'b1000000
    } t_phase;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_EMIT = 4'b0100,
        ST_BITS = 4'b1000
    } t_state;

    localparam logic [2:0] FMT_P1 = 3'd1;
    localparam logic [2:0] FMT_P2 = 3'd2;
    localparam logic [2:0] FMT_P3 = 3'd3;
    localparam logic [2:0] FMT_P4 = 3'd4;
    localparam logic [2:0] FMT_P5 = 3'd5;
    localparam logic [2:0] FMT_P6 = 3'd6;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_MAGIC  = 2'd1;
    localparam logic [1:0] ERR_HEADER = 2'd2;

    localparam logic [1:0] DEPTH_BW   = 2'd0;
    localparam logic [1:0] DEPTH_GREY = 2'd1;
    localparam logic [1:0] DEPTH_RGB  = 2'd2;

    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_1    = 8'h31;
    localparam logic [7:0] CH_6    = 8'h36;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_LF   = 8'h0a;
    localparam logic [7:0] CH_CR   = 8'h0d;

    localparam logic [7:0] GREY_MID = 8'd128;
    localparam logic [7:0] FULL     = 8'd255;

    localparam int unsigned TDATA_W = 56;

    function automatic logic [1:0] depth_of(input logic [2:0] fmt);
        logic [1:0] d;
        d = DEPTH_RGB;
        if (fmt == FMT_P1 || fmt == FMT_P4) d = DEPTH_BW;
        else if (fmt == FMT_P2 || fmt == FMT_P5) d = DEPTH_GREY;
        return d;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
    endfunction

endpackage

// ===== rtl/core/nsd_div.sv =====
// iterative restoring divider, one quotient bit per cycle, quotient below 256
module nsd_div import nsd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_dividend,
    input  logic [7:0]  i_divisor,
    output logic        o_done,
    output logic [7:0]  o_quotient
);
    logic       r_busy, n_busy;
    logic       r_done, n_done;
    logic [2:0] r_cnt, n_cnt;
    logic [7:0] r_rem, n_rem;
    logic [7:0] r_low, n_low;
    logic [7:0] r_dvs, n_dvs;
    logic [7:0] r_quo, n_quo;
    logic [8:0] trial;
    logic       qbit;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_low  = r_low;
        n_dvs  = r_dvs;
        n_quo  = r_quo;
        trial  = {r_rem, r_low[7]};
        qbit   = trial >= {1'b0, r_dvs};
        if (i_start) begin
            // upper byte is already below the divisor
            n_busy = 1'b1;
            n_cnt  = 3'd0;
            n_rem  = i_dividend[15:8];
            n_low  = i_dividend[7:0];
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = qbit ? 8'(trial - {1'b0, r_dvs}) : trial[7:0];
            n_low = {r_low[6:0], 1'b0};
            n_quo = {r_quo[6:0], qbit};
            n_cnt = 3'(r_cnt + 3'd1);
            if (r_cnt == 3'd7) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_low <= n_low;
        r_dvs <= n_dvs;
        r_quo <= n_quo;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

// ===== rtl/core/netpbm_stream_decoder_core.sv =====
// top level of the netpbm (p1..p6) stream decoder
// one input word is one file byte (tuser low) or an end-of-stream marker (tuser high).
// the header parse, p1/p5/p6 samples and error words go from the accept through
// the emit state into the output register; ascii p2/p3 samples are scaled by
// value*255/maxval through a shared bit-serial divider; a p4 byte gives up to eight
// pixels, one per cycle while the sink does not stall. input ready is held low while
// a word is in flight and whenever the output register is stalled by the sink.
// after an error word or the last pixel every input word is taken and dropped
// until reset. rows count bottom-up: the first file line is row height-1.
module netpbm_stream_decoder_core import nsd_pkg::*; #(
    parameter int unsigned MAX_DIM = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [7:0]         i_s_tdata,   // data_byte
    input  logic               i_s_tuser,   // cmd
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [TDATA_W-1:0] o_m_tdata,   // error_code, depth_kind, red, green, blue,
                                            // column, row, zero pad
    output logic               o_m_tuser,   // kind
    output logic               o_m_tlast    // last
);
    localparam int unsigned ACC_CAP = (MAX_DIM > 255 ? MAX_DIM : 255) + 1;
    localparam int unsigned AW      = $clog2(ACC_CAP + 1);
    localparam int unsigned DW      = $clog2(MAX_DIM + 1);
    localparam int unsigned CW      = DW > 12 ? DW : 12;

    t_state        r_state, n_state;
    t_phase        r_phase, n_phase;
    logic [2:0]    r_fmt, n_fmt;
    logic [DW-1:0] r_width, n_width;
    logic [DW-1:0] r_height, n_height;
    logic [7:0]    r_smax, n_smax;
    logic [AW-1:0] r_acc, n_acc;
    logic          r_in_cmt, n_in_cmt;
    logic          r_in_num, n_in_num;
    logic [1:0]    r_comp, n_comp;
    logic [7:0]    r_pr, n_pr, r_pg, n_pg;
    logic [DW-1:0] r_col, n_col;
    logic [DW-1:0] r_line, n_line;
    // pending result for the output register
    logic [7:0]    r_qr, n_qr, r_qg, n_qg, r_qb, n_qb;
    logic [1:0]    r_qerr, n_qerr;
    logic [7:0]    r_byte, n_byte;
    logic [2:0]    r_bit, n_bit;
    logic          r_div_fill, n_div_fill;
    // output register
    logic               r_ov, n_ov;
    logic [TDATA_W-1:0] r_od, n_od;
    logic               r_ou, n_ou;
    logic               r_ol, n_ol;

    logic          s_fire, slot_free;
    logic [7:0]    c;
    logic          is_dg, is_sp, is_eol;
    logic [AW+3:0] acc_mul;
    logic [AW-1:0] acc_sat;
    logic          hdr_ok;
    logic          div_start, div_done;
    logic [7:0]    div_q, clamp_v;
    logic [AW-1:0] r_div_src, n_div_src;
    logic [15:0]   div_dvd;
    logic          emit_px, emit_err, fin;
    logic [7:0]    er, eg, eb;
    logic [DW:0]   col_inc, line_inc;
    logic [CW-1:0] row_full;
    logic [7:0]    bitval;

    assign s_fire    = i_s_tvalid && o_s_tready;
    assign slot_free = !r_ov || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE) && slot_free;

    assign c      = i_s_tdata;
    assign is_dg  = c >= CH_0 && c <= CH_9;
    assign is_sp  = is_space(c);
    assign is_eol = c == CH_LF || c == CH_CR;

    // saturating decimal accumulate
    assign acc_mul = ((AW+4)'(r_acc) << 3) + ((AW+4)'(r_acc) << 1) + (AW+4)'(c - CH_0);
    assign acc_sat = acc_mul > (AW+4)'(ACC_CAP) ? AW'(ACC_CAP) : acc_mul[AW-1:0];

    assign hdr_ok = r_acc != '0 &&
                    (r_phase == PH_MAXVAL ? r_acc <= AW'(255) : r_acc <= AW'(MAX_DIM));

    // clamp to maxval then form value*255 for the divider, taken as the divider starts
    assign clamp_v = n_div_src > AW'(n_smax) ? n_smax : n_div_src[7:0];
    assign div_dvd = {clamp_v, 8'd0} - {8'd0, clamp_v};

    nsd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (n_smax),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign bitval = r_byte[r_bit] ? 8'd0 : FULL;

    always_comb begin
        n_state = r_state;  n_phase = r_phase;  n_fmt = r_fmt;
        n_width = r_width;  n_height = r_height; n_smax = r_smax;
        n_acc = r_acc;      n_in_cmt = r_in_cmt; n_in_num = r_in_num;
        n_comp = r_comp;    n_pr = r_pr;         n_pg = r_pg;
        n_col = r_col;      n_line = r_line;
        n_qr = r_qr; n_qg = r_qg; n_qb = r_qb; n_qerr = r_qerr;
        n_byte = r_byte; n_bit = r_bit; n_div_fill = r_div_fill;
        n_div_src = r_div_src;
        n_ov = r_ov && !i_m_tready; n_od = r_od; n_ou = r_ou; n_ol = r_ol;
        div_start = 1'b0;
        emit_px = 1'b0; emit_err = 1'b0;
        er = r_qr; eg = r_qg; eb = r_qb;
        fin = 1'b0;
        col_inc = '0; line_inc = '0; row_full = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (s_fire && r_phase != PH_DONE) begin
                    if (r_phase == PH_MAGIC_P || r_phase == PH_MAGIC_D) begin
                        if (i_s_tuser || (r_phase == PH_MAGIC_P && c != CH_P) ||
                            (r_phase == PH_MAGIC_D && (c < CH_1 || c > CH_6))) begin
                            n_qerr = ERR_MAGIC; n_phase = PH_DONE; n_state = ST_EMIT;
                        end else if (r_phase == PH_MAGIC_P) begin
                            n_phase = PH_MAGIC_D;
                        end else begin
                            n_fmt = c[2:0]; n_phase = PH_WIDTH;
                        end
                    end else if (r_phase != PH_PIXELS) begin
                        // header values
                        if (i_s_tuser) begin
                            if (!r_in_num || !hdr_ok || r_phase == PH_WIDTH ||
                                (r_phase == PH_HEIGHT && r_fmt != FMT_P1 &&
                                 r_fmt != FMT_P4)) begin
                                n_qerr = ERR_HEADER; n_phase = PH_DONE; n_state = ST_EMIT;
                            end else begin
                                n_acc = '0; n_in_num = 1'b0;
                                n_phase = PH_PIXELS;
                                n_comp = 2'd0;
                                if (r_phase == PH_HEIGHT) begin
                                    n_height = DW'(r_acc); n_smax = FULL;
                                    n_qr = GREY_MID; n_qg = GREY_MID; n_qb = GREY_MID;
                                    n_qerr = ERR_NONE; n_state = ST_EMIT;
                                end else begin
                                    n_smax = r_acc[7:0];
                                    if (r_fmt == FMT_P2 || r_fmt == FMT_P3) begin
                                        n_div_src = '0; n_div_fill = 1'b1;
                                        n_state = ST_DIV;
                                    end else begin
                                        n_qr = GREY_MID; n_qg = GREY_MID; n_qb = GREY_MID;
                                        n_qerr = ERR_NONE; n_state = ST_EMIT;
                                    end
                                end
                            end
                        end else if (r_in_cmt) begin
                            if (is_eol) n_in_cmt = 1'b0;
                        end else if (is_dg) begin
                            n_acc = acc_sat; n_in_num = 1'b1;
                        end else begin
                            if (c == CH_HASH) n_in_cmt = 1'b1;
                            if (r_in_num) begin
                                n_acc = '0; n_in_num = 1'b0;
                                if (!hdr_ok) begin
                                    n_qerr = ERR_HEADER; n_phase = PH_DONE;
                                    n_state = ST_EMIT;
                                end else if (r_phase == PH_WIDTH) begin
                                    n_width = DW'(r_acc); n_phase = PH_HEIGHT;
                                end else if (r_phase == PH_HEIGHT) begin
                                    n_height = DW'(r_acc);
                                    if (r_fmt == FMT_P1 || r_fmt == FMT_P4) begin
                                        n_smax = FULL; n_phase = PH_PIXELS;
                                    end else begin
                                        n_phase = PH_MAXVAL;
                                    end
                                end else begin
                                    n_smax = r_acc[7:0]; n_phase = PH_PIXELS;
                                end
                            end else if (c != CH_HASH && !is_sp) begin
                                n_qerr = ERR_HEADER; n_phase = PH_DONE; n_state = ST_EMIT;
                            end
                        end
                    end else if (i_s_tuser) begin
                        // end of stream: one fill pixel
                        if (r_fmt == FMT_P2 || r_fmt == FMT_P3) begin
                            n_div_src = r_in_num ? r_acc : '0;
                            n_acc = '0; n_in_num = 1'b0;
                            n_div_fill = 1'b1; n_state = ST_DIV;
                        end else begin
                            n_comp = 2'd0;
                            n_qr = GREY_MID; n_qg = GREY_MID; n_qb = GREY_MID;
                            n_qerr = ERR_NONE; n_state = ST_EMIT;
                        end
                    end else if (r_in_cmt) begin
                        if (is_eol) n_in_cmt = 1'b0;
                    end else begin
                        n_qerr = ERR_NONE;
                        case (r_fmt)
                            FMT_P1: begin
                                if (c == CH_HASH) begin
                                    n_in_cmt = 1'b1;
                                end else if (!is_sp) begin
                                    n_state = ST_EMIT;
                                    n_qr = c == CH_0 ? FULL : (is_dg ? 8'd0 : GREY_MID);
                                    n_qg = n_qr; n_qb = n_qr;
                                end
                            end
                            FMT_P2, FMT_P3: begin
                                if (is_dg) begin
                                    n_acc = acc_sat; n_in_num = 1'b1;
                                end else begin
                                    if (c == CH_HASH) n_in_cmt = 1'b1;
                                    n_div_fill = 1'b0;
                                    if (r_in_num) begin
                                        n_div_src = r_acc; n_acc = '0; n_in_num = 1'b0;
                                        n_state = ST_DIV;
                                    end else if (c != CH_HASH && !is_sp) begin
                                        n_div_src = '0; n_state = ST_DIV;
                                    end
                                end
                            end
                            FMT_P4: begin
                                n_byte = c; n_bit = 3'd7; n_state = ST_BITS;
                            end
                            FMT_P5: begin
                                n_qr = c; n_qg = c; n_qb = c; n_state = ST_EMIT;
                            end
                            default: begin
                                if (r_comp == 2'd0) begin
                                    n_pr = c; n_comp = 2'd1;
                                end else if (r_comp == 2'd1) begin
                                    n_pg = c; n_comp = 2'd2;
                                end else begin
                                    n_comp = 2'd0; n_qr = r_pr; n_qg = r_pg; n_qb = c;
                                    n_state = ST_EMIT;
                                end
                            end
                        endcase
                    end
                    div_start = n_state == ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_qerr = ERR_NONE;
                    if (r_div_fill) begin
                        if (r_fmt == FMT_P2) begin
                            n_qr = div_q; n_qg = div_q; n_qb = div_q;
                        end else begin
                            n_qr = r_comp == 2'd0 ? div_q : r_pr;
                            n_qg = r_comp == 2'd1 ? div_q : (r_comp == 2'd2 ? r_pg : 8'd0);
                            n_qb = r_comp == 2'd2 ? div_q : 8'd0;
                        end
                        n_comp = 2'd0; n_state = ST_EMIT;
                    end else if (r_fmt == FMT_P2) begin
                        n_qr = div_q; n_qg = div_q; n_qb = div_q; n_state = ST_EMIT;
                    end else if (r_comp == 2'd0) begin
                        n_pr = div_q; n_comp = 2'd1; n_state = ST_IDLE;
                    end else if (r_comp == 2'd1) begin
                        n_pg = div_q; n_comp = 2'd2; n_state = ST_IDLE;
                    end else begin
                        n_comp = 2'd0; n_qr = r_pr; n_qg = r_pg; n_qb = div_q;
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    if (r_qerr != ERR_NONE) emit_err = 1'b1;
                    else emit_px = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_BITS: begin
                if (slot_free) begin
                    emit_px = 1'b1;
                    er = bitval; eg = bitval; eb = bitval;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (emit_err) begin
            n_ov = 1'b1; n_ou = 1'b1; n_ol = 1'b1;
            n_od = TDATA_W'(r_qerr);
        end
        if (emit_px) begin
            // advance column and line, flag the final pixel
            col_inc  = {1'b0, r_col} + 1'b1;
            line_inc = {1'b0, r_line} + 1'b1;
            row_full = CW'(r_height) - CW'(1) - CW'(r_line);
            n_col = col_inc[DW-1:0];
            if (col_inc >= {1'b0, r_width}) begin
                n_col  = '0;
                n_line = line_inc[DW-1:0];
                fin    = line_inc >= {1'b0, r_height};
            end
            if (fin) n_phase = PH_DONE;
            n_ov = 1'b1; n_ou = 1'b0; n_ol = fin;
            n_od = {4'd0, row_full[11:0], CW'(r_col) >> 0 == '0 ? 12'd0 : 12'(CW'(r_col)),
                    eb, eg, er, depth_of(r_fmt), ERR_NONE};
            if (r_state == ST_BITS) begin
                if (fin || n_col == '0 || r_bit == 3'd0) n_state = ST_IDLE;
                n_bit = 3'(r_bit - 3'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_phase  <= PH_MAGIC_P;
            r_fmt    <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_smax   <= '0;
            r_acc    <= '0;
            r_in_cmt <= 1'b0;
            r_in_num <= 1'b0;
            r_comp   <= '0;
            r_pr     <= '0;
            r_pg     <= '0;
            r_col    <= '0;
            r_line   <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_fmt    <= n_fmt;
            r_width  <= n_width;
            r_height <= n_height;
            r_smax   <= n_smax;
            r_acc    <= n_acc;
            r_in_cmt <= n_in_cmt;
            r_in_num <= n_in_num;
            r_comp   <= n_comp;
            r_pr     <= n_pr;
            r_pg     <= n_pg;
            r_col    <= n_col;
            r_line   <= n_line;
            r_ov     <= n_ov;
        end
        r_qr       <= n_qr;
        r_qg       <= n_qg;
        r_qb       <= n_qb;
        r_qerr     <= n_qerr;
        r_byte     <= n_byte;
        r_bit      <= n_bit;
        r_div_fill <= n_div_fill;
        r_div_src  <= n_div_src;
        r_od       <= n_od;
        r_ou       <= n_ou;
        r_ol       <= n_ol;
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_od;
    assign o_m_tuser  = r_ou;
    assign o_m_tlast  = r_ol;
endmodule

// ===== rtl/core/nsd_checker.sv =====
// port-level checks for the netpbm stream decoder, bound to the top level
module nsd_checker import nsd_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_s_tvalid,
    input logic               o_s_tready,
    input logic               o_m_tvalid,
    input logic               i_m_tready,
    input logic [TDATA_W-1:0] o_m_tdata,
    input logic               o_m_tuser,
    input logic               o_m_tlast
);
    // a stalled word stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid) else $error("output word dropped");

    // an error word always closes the stream
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tlast) else $error("error word without last");

    // error word carries a code and nothing else
    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata[1:0] != ERR_NONE && o_m_tdata[51:2] == '0)
        else $error("error word fields");

    // a pixel word never carries an error code
    a_px_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[1:0] == ERR_NONE)
        else $error("pixel word with error code");

    // a word just sent with last is not followed by input being refused forever
    a_ready_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_m_tvalid && i_m_tready && o_m_tlast) && !o_m_tvalid |-> o_s_tready)
        else $error("decoder stuck after final word");
endmodule

bind netpbm_stream_decoder_core nsd_checker u_nsd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

// ===== sim/netpbm_stream_decoder_core_check.sv =====
// scoreboard for the netpbm stream decoder: byte-level decode prediction and result compare
`timescale 1ns / 100ps
module netpbm_stream_decoder_core_check import nsd_pkg::*; #(
    parameter int unsigned MAX_DIM = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    input  logic               o_s_tready,
    input  logic [7:0]         i_s_tdata,   // data_byte
    input  logic               i_s_tuser,   // cmd
    input  logic               o_m_tvalid,
    input  logic               i_m_tready,
    input  logic [TDATA_W-1:0] o_m_tdata,   // error_code, depth_kind, red, green, blue,
                                            // column, row, zero pad
    input  logic               o_m_tuser,   // kind
    input  logic               o_m_tlast,   // last
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_word_count
);

    typedef struct {
        logic        kind;
        logic [1:0]  err;
        logic [1:0]  depth;
        logic [7:0]  red, green, blue;
        logic [11:0] col, row;
        logic        last;
    } t_pixel_word;

    localparam int NUM_CAP = ((MAX_DIM > 255) ? MAX_DIM : 255) + 1;

    t_pixel_word expected_words[$];

    // decoder state, mirrored
    t_phase     phase;
    logic [2:0] fmt;
    int         img_w, img_h, max_val, num_acc, comp_idx, col_cnt, line_cnt;
    bit         in_cmt, in_num;
    logic [7:0] part_r, part_g;

    function automatic bit blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == CH_LF || c == 8'h0b || c == 8'h0c || c == CH_CR;
    endfunction

    function automatic bit digit(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic int scaled(input int v);
        int s;
        s = v;
        if (max_val == 0) return 0;
        if (s > max_val) s = max_val;
        return (s * 255) / max_val;
    endfunction

    task automatic push_error(input logic [1:0] code);
        t_pixel_word w;
        w = '{kind: 1'b1, err: code, depth: DEPTH_BW, red: 8'd0, green: 8'd0, blue: 8'd0,
              col: 12'd0, row: 12'd0, last: 1'b1};
        expected_words.push_back(w);
        phase = PH_DONE;
    endtask

    task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        t_pixel_word w;
        int          row_v;
        if (phase != PH_PIXELS) return;
        row_v = img_h - 1 - line_cnt;
        w.kind  = 1'b0;
        w.err   = ERR_NONE;
        w.depth = (fmt == FMT_P1 || fmt == FMT_P4) ? DEPTH_BW :
                  (fmt == FMT_P2 || fmt == FMT_P5) ? DEPTH_GREY : DEPTH_RGB;
        w.red   = r;
        w.green = g;
        w.blue  = b;
        w.col   = col_cnt[11:0];
        w.row   = row_v[11:0];
        w.last  = 1'b0;
        col_cnt++;
        if (col_cnt >= img_w) begin
            col_cnt = 0;
            line_cnt++;
            if (line_cnt >= img_h) begin
                w.last = 1'b1;
                phase  = PH_DONE;
            end
        end
        expected_words.push_back(w);
    endtask

    task automatic add_digit(input logic [7:0] c);
        int v;
        v = num_acc * 10 + int'(c - CH_0);
        num_acc = (v > NUM_CAP) ? NUM_CAP : v;
        in_num = 1'b1;
    endtask

    // closes the header value in progress, ok low when it is out of range
    task automatic close_value(output bit ok);
        int v;
        v = num_acc;
        num_acc = 0;
        in_num = 1'b0;
        ok = 1'b1;
        if (phase == PH_WIDTH) begin
            if (v == 0 || v > MAX_DIM) ok = 1'b0;
            else begin
                img_w = v;
                phase = PH_HEIGHT;
            end
        end else if (phase == PH_HEIGHT) begin
            if (v == 0 || v > MAX_DIM) ok = 1'b0;
            else begin
                img_h = v;
                if (fmt == FMT_P1 || fmt == FMT_P4) begin
                    max_val = 255;
                    phase = PH_PIXELS;
                end else begin
                    phase = PH_MAXVAL;
                end
            end
        end else begin
            if (v == 0 || v > 255) ok = 1'b0;
            else begin
                max_val = v;
                phase = PH_PIXELS;
            end
        end
    endtask

    task automatic text_sample(input int s);
        if (fmt == FMT_P2) begin
            push_pixel(8'(s), 8'(s), 8'(s));
        end else if (comp_idx == 0) begin
            part_r = 8'(s);
            comp_idx = 1;
        end else if (comp_idx == 1) begin
            part_g = 8'(s);
            comp_idx = 2;
        end else begin
            comp_idx = 0;
            push_pixel(part_r, part_g, 8'(s));
        end
    endtask

    // end-of-stream word: one padding pixel
    task automatic pad_pixel();
        int cur, r, g, b;
        if (fmt == FMT_P2 || fmt == FMT_P3) begin
            cur = 0;
            if (in_num) begin
                cur = scaled(num_acc);
                num_acc = 0;
                in_num = 1'b0;
            end
            if (fmt == FMT_P2) begin
                push_pixel(8'(cur), 8'(cur), 8'(cur));
                return;
            end
            r = (comp_idx == 0) ? cur : int'(part_r);
            g = (comp_idx == 1) ? cur : ((comp_idx == 2) ? int'(part_g) : 0);
            b = (comp_idx == 2) ? cur : 0;
            comp_idx = 0;
            push_pixel(8'(r), 8'(g), 8'(b));
            return;
        end
        comp_idx = 0;
        push_pixel(GREY_MID, GREY_MID, GREY_MID);
    endtask

    task automatic body_byte(input logic [7:0] c);
        logic [7:0] v;
        case (fmt)
            FMT_P1: begin
                if (c == CH_HASH) in_cmt = 1'b1;
                else if (blank(c)) ;
                else if (c == CH_0) push_pixel(FULL, FULL, FULL);
                else if (c >= CH_1 && c <= CH_9) push_pixel(8'd0, 8'd0, 8'd0);
                else push_pixel(GREY_MID, GREY_MID, GREY_MID);
            end
            FMT_P2, FMT_P3: begin
                if (digit(c)) begin
                    add_digit(c);
                end else begin
                    if (c == CH_HASH) in_cmt = 1'b1;
                    if (in_num) begin
                        text_sample(scaled(num_acc));
                        num_acc = 0;
                        in_num = 1'b0;
                    end else if (c != CH_HASH && !blank(c)) begin
                        text_sample(0);
                    end
                end
            end
            FMT_P4: begin
                // msb first, a set bit is black, stop at the end of a row
                for (int k = 7; k >= 0; k--) begin
                    v = c[k] ? 8'd0 : FULL;
                    push_pixel(v, v, v);
                    if (col_cnt == 0 || phase != PH_PIXELS) break;
                end
            end
            FMT_P5: push_pixel(c, c, c);
            default: begin
                if (comp_idx == 0) begin
                    part_r = c;
                    comp_idx = 1;
                end else if (comp_idx == 1) begin
                    part_g = c;
                    comp_idx = 2;
                end else begin
                    comp_idx = 0;
                    push_pixel(part_r, part_g, c);
                end
            end
        endcase
    endtask

    task automatic decode_word(input logic cmd, input logic [7:0] c);
        bit ok;
        if (phase == PH_DONE) return;
        if (phase == PH_MAGIC_P || phase == PH_MAGIC_D) begin
            if (cmd) push_error(ERR_MAGIC);
            else if (phase == PH_MAGIC_P) begin
                if (c != CH_P) push_error(ERR_MAGIC);
                else phase = PH_MAGIC_D;
            end else begin
                if (c < CH_1 || c > CH_6) push_error(ERR_MAGIC);
                else begin
                    fmt = 3'(c - CH_0);
                    phase = PH_WIDTH;
                end
            end
            return;
        end
        if (phase != PH_PIXELS) begin
            if (cmd) begin
                if (!in_num) begin
                    push_error(ERR_HEADER);
                    return;
                end
                close_value(ok);
                if (!ok || phase != PH_PIXELS) push_error(ERR_HEADER);
                else pad_pixel();
                return;
            end
            if (in_cmt) begin
                if (c == CH_LF || c == CH_CR) in_cmt = 1'b0;
                return;
            end
            if (digit(c)) begin
                add_digit(c);
                return;
            end
            if (c == CH_HASH) in_cmt = 1'b1;
            if (in_num) begin
                close_value(ok);
                if (!ok) push_error(ERR_HEADER);
            end else if (c != CH_HASH && !blank(c)) begin
                push_error(ERR_HEADER);
            end
            return;
        end
        if (cmd) begin
            pad_pixel();
            return;
        end
        if (in_cmt) begin
            if (c == CH_LF || c == CH_CR) in_cmt = 1'b0;
            return;
        end
        body_byte(c);
    endtask

    task automatic report(input string what, input int got, input int want);
        $display("mismatch at %0t on word %0d: %s got %0d, expected %0d",
                 $realtime, o_word_count, what, got, want);
        o_fail_count++;
    endtask

    task automatic compare_word();
        t_pixel_word w;
        if (expected_words.size() == 0) begin
            report("unexpected word, kind", o_m_tuser, 0);
            return;
        end
        w = expected_words.pop_front();
        if (o_m_tuser !== w.kind)             report("kind", o_m_tuser, w.kind);
        if (o_m_tdata[1:0] !== w.err)         report("error_code", o_m_tdata[1:0], w.err);
        if (o_m_tdata[3:2] !== w.depth)       report("depth_kind", o_m_tdata[3:2], w.depth);
        if (o_m_tdata[11:4] !== w.red)        report("red", o_m_tdata[11:4], w.red);
        if (o_m_tdata[19:12] !== w.green)     report("green", o_m_tdata[19:12], w.green);
        if (o_m_tdata[27:20] !== w.blue)      report("blue", o_m_tdata[27:20], w.blue);
        if (o_m_tdata[39:28] !== w.col)       report("column", o_m_tdata[39:28], w.col);
        if (o_m_tdata[51:40] !== w.row)       report("row", o_m_tdata[51:40], w.row);
        if (o_m_tlast !== w.last)             report("last", o_m_tlast, w.last);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase = PH_MAGIC_P;
            fmt = '0;
            img_w = 0; img_h = 0; max_val = 0; num_acc = 0;
            in_cmt = 1'b0; in_num = 1'b0; comp_idx = 0;
            part_r = '0; part_g = '0; col_cnt = 0; line_cnt = 0;
            expected_words.delete();
            o_fail_count = 0;
            o_word_count = 0;
        end else begin
            if (i_s_tvalid && o_s_tready) decode_word(i_s_tuser, i_s_tdata);
            if (o_m_tvalid && i_m_tready) begin
                compare_word();
                o_word_count++;
            end
        end
        o_pending = expected_words.size();
    end

endmodule

// ===== sim/netpbm_stream_decoder_core_test.sv =====
// stimulus and verdict for the netpbm stream decoder core
`timescale 1ns / 100ps
module netpbm_stream_decoder_core_test;
    import nsd_pkg::*;

    localparam int MAX_DIM = 4096;
    localparam int ITEMS   = 260;
    localparam int LIMIT   = 1500000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_s_tvalid = 1'b0;
    logic               o_s_tready;
    logic [7:0]         i_s_tdata = '0;      // data_byte
    logic               i_s_tuser = 1'b0;    // cmd
    logic               o_m_tvalid;
    logic               i_m_tready = 1'b0;
    logic [TDATA_W-1:0] o_m_tdata;          // error_code, depth_kind, red, green, blue,
                                            // column, row, zero pad
    logic               o_m_tuser;          // kind
    logic               o_m_tlast;          // last

    int fail_count, pending, out_words;
    int cycles = 0;
    int sent = 0;
    bit quiet = 1'b0;
    bit image_over = 1'b0;
    int stall_left = 0;

    netpbm_stream_decoder_core #(.MAX_DIM(MAX_DIM)) dut (.*);

    netpbm_stream_decoder_core_check #(.MAX_DIM(MAX_DIM)) checker_inst (
        .i_clk, .i_rst_n, .i_s_tvalid, .o_s_tready, .i_s_tdata, .i_s_tuser,
        .o_m_tvalid, .i_m_tready, .o_m_tdata, .o_m_tuser, .o_m_tlast,
        .o_fail_count(fail_count), .o_pending(pending), .o_word_count(out_words)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected", cycles, pending);
            $display("netpbm_stream_decoder_core verification failed");
            $finish;
        end
    end

    // sink side: random stall bursts, none in the quiet tail
    always @(posedge i_clk) begin
        if (quiet) begin
            i_m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 6);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // an error word or the final pixel closes the image
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready && o_m_tlast) image_over <= 1'b1;
    end

    task automatic send_word(input logic cmd, input logic [7:0] c);
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= c;
        do @(posedge i_clk); while (!o_s_tready);
        sent++;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 7);
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= 8'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_word(1'b0, s[i]);
    endtask

    // separator after a header value: blank, a comment or a bare hash
    task automatic send_gap();
        case ($urandom_range(0, 5))
            0: send_text("\n");
            1: send_text("\t");
            2: send_text(" # note\r");
            3: send_text("#\n");
            4: send_text(" \n  ");
            default: send_text(" ");
        endcase
    endtask

    task automatic send_body_byte(input logic [2:0] fmt, input int max_val);
        int n;
        if ($urandom_range(0, 39) == 0) begin
            send_word(1'b1, 8'($urandom));
            return;
        end
        case (fmt)
            FMT_P1: begin
                case ($urandom_range(0, 9))
                    0: send_text(" ");
                    1: send_text("\n");
                    2: send_text("#c\n");
                    3: send_word(1'b0, 8'($urandom));
                    4: send_word(1'b0, 8'(CH_1 + $urandom_range(0, 8)));
                    default: send_word(1'b0, $urandom_range(0, 1) ? CH_0 : CH_1);
                endcase
            end
            FMT_P2, FMT_P3: begin
                case ($urandom_range(0, 11))
                    0: send_text("x ");
                    1: send_text("#skip 7\n");
                    2: send_text("0000 ");
                    default: begin
                        // mostly in range, some above maxval to exercise clamping
                        n = $urandom_range(0, 3) == 0 ? $urandom_range(0, 999)
                                                      : $urandom_range(0, max_val);
                        send_text($sformatf("%0d", n));
                        send_text($urandom_range(0, 1) ? " " : "\n");
                    end
                endcase
            end
            default: send_word(1'b0, 8'($urandom));
        endcase
    endtask

    // header faults: bad magic letter or digit, empty or out-of-range values, early end-of-stream markers
    task automatic send_broken_header();
        case ($urandom_range(0, 7))
            0: send_word(1'b0, 8'($urandom_range(0, 79)));
            1: send_text("P0");
            2: send_text("P7");
            3: begin send_text("P"); send_word(1'b1, 8'h00); end
            4: send_text("P2 0 ");
            5: send_text("P5 4097 3 ");
            6: send_text("P3 4 2 256 ");
            default: begin send_text("P6 4 "); send_word(1'b1, 8'hff); end
        endcase
    endtask

    initial begin
        logic [2:0] fmt;
        int         img_w, img_h, max_val, shape;
        bit         broken;

        fmt     = 3'($urandom_range(1, 6));
        broken  = ($urandom_range(0, 7) == 0);
        shape   = $urandom_range(0, 9);
        img_w   = $urandom_range(1, 12);
        img_h   = $urandom_range(1, 8);
        if (shape == 0) begin
            img_w = MAX_DIM;
            img_h = 1;
        end else if (shape == 1) begin
            img_w = 1;
            img_h = MAX_DIM;
        end
        case ($urandom_range(0, 3))
            0: max_val = 255;
            1: max_val = 1;
            default: max_val = $urandom_range(1, 255);
        endcase

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        if (broken) begin
            send_broken_header();
        end else begin
            // header, sometimes with leading zeros on the width, and with blanks or comments between values
            send_word(1'b0, CH_P);
            send_word(1'b0, CH_0 + fmt);
            send_gap();
            if ($urandom_range(0, 3) == 0) send_text("00");
            send_text($sformatf("%0d", img_w));
            send_gap();
            if (fmt == FMT_P1 || fmt == FMT_P4) begin
                send_text($sformatf("%0d", img_h));
            end else begin
                send_text($sformatf("%0d", img_h));
                send_gap();
                send_text($sformatf("%0d", max_val));
            end
            // the last value ends in a single newline byte or in a comment
            if ($urandom_range(0, 3) == 0) send_text("#end of header\n");
            else send_text("\n");

            // extremes of the data first
            if (fmt == FMT_P5 || fmt == FMT_P6 || fmt == FMT_P4) begin
                send_word(1'b0, 8'h00);
                send_word(1'b0, 8'hff);
                send_word(1'b0, 8'haa);
            end else if (fmt == FMT_P1) begin
                send_text("0 1 9 z");
            end else begin
                send_text($sformatf("0 %0d 999 ", max_val));
            end

            while (sent < ITEMS * 3 / 4 && !image_over) begin
                if (sent > ITEMS * 3 / 5) quiet = 1'b1;
                send_body_byte(fmt, max_val);
            end
        end

        // padding words close a small image; a full-size row or column stays open
        quiet = 1'b1;
        while (!image_over && sent < ITEMS + 40) send_word(1'b1, 8'($urandom));
        // everything after the close is dropped
        if (image_over) begin
            repeat (8) send_word(1'($urandom), 8'($urandom));
            while (sent < ITEMS) send_word(1'($urandom), 8'($urandom));
        end
        i_s_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("format P%0d, %0d x %0d, maxval %0d%s", fmt, img_w, img_h, max_val,
                 broken ? ", broken header" : "");
        $display("%0d input words sent, %0d output words checked, %0d mismatches",
                 sent, out_words, fail_count);
        if (fail_count == 0) begin
            $display("netpbm_stream_decoder_core verification clean");
        end else begin
            $display("netpbm_stream_decoder_core verification failed");
        end
        $finish;
    end

endmodule

// ===== netpbm_stream_decoder_core.f =====
rtl/core/nsd_pkg.sv
rtl/core/nsd_div.sv
rtl/core/netpbm_stream_decoder_core.sv
rtl/core/nsd_checker.sv
sim/netpbm_stream_decoder_core_check.sv
sim/netpbm_stream_decoder_core_test.sv
